// ----- rtl/banked_wave_sound_channel_defines.svh -----
// Assertion macros used by the wave channel RTL.
`ifndef BANKED_WAVE_SOUND_CHANNEL_DEFINES_SVH
`define BANKED_WAVE_SOUND_CHANNEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BWSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bwsc assertion failed");

// Next-cycle implication, checked outside reset.
`define BWSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bwsc assertion failed");

`endif

// ----- rtl/bwsc_pkg.sv -----
// Package: command and register codes, stage type and volume table for the wave channel.
package bwsc_pkg;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_LENGTH  = 3'd1;
  localparam logic [2:0] CMD_REG_WR  = 3'd2;
  localparam logic [2:0] CMD_REG_RD  = 3'd3;
  localparam logic [2:0] CMD_RAM_WR  = 3'd4;
  localparam logic [2:0] CMD_RAM_RD  = 3'd5;

  localparam logic [3:0] REG_CTRL    = 4'd0;
  localparam logic [3:0] REG_LENGTH  = 4'd1;
  localparam logic [3:0] REG_VOLUME  = 4'd2;
  localparam logic [3:0] REG_FREQ_LO = 4'd3;
  localparam logic [3:0] REG_FREQ_HI = 4'd4;

  localparam logic [11:0] PERIOD_BASE = 12'd2048;

  // Item in flight between the memory read and the result register.
  typedef struct packed {
    logic       is_tick;
    logic       fetch;
    logic       nib_lo;
    logic       is_ram_rd;
    logic [7:0] rd_reg;
    logic       chan_on;
    logic [2:0] vol;
  } a_stage_t;

  // Volume scale in quarters.
  function automatic logic [2:0] vol_mult(input logic [2:0] code);
    logic [2:0] m;
    case (code)
      3'd0:    m = 3'd0;
      3'd1:    m = 3'd4;
      3'd2:    m = 3'd2;
      3'd3:    m = 3'd1;
      default: m = 3'd3;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/banked_wave_sound_channel.sv -----
// Top level: banked wave sound channel with a two-bank 4-bit pattern store.
//
// Each transaction on the slave stream carries one command (tick, length
// clock, register write, register read, wave RAM write, wave RAM read) and
// produces exactly one result transaction on the master stream, in order.
// The block takes a new command every cycle and stalls only when the master
// side holds off. A result is offered once the result register is loaded:
// the accept edge registers the pattern store read, and a later edge, when
// the master side can take the result, loads the result register. Register
// and counter state is updated at the accept edge, so a
// command sees everything that earlier commands changed. The pattern store
// is 32 bytes (two 32-entry banks of 4-bit samples, two samples per byte)
// with one write port and one registered read port; a per-byte valid flag
// cleared by reset makes never-written bytes read as zero, so no clearing
// pass is needed after reset. The sample output holds the last scaled value
// between ticks and is set to zero by each tick while the channel is off.
module banked_wave_sound_channel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] command, [6:3] address, [14:7] write_data, [15] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_data, [11:8] sample, [15:12] zero
);

`include "banked_wave_sound_channel_defines.svh"

  // Input fields
  logic [2:0] command;
  logic [3:0] address;
  logic [7:0] write_data;
  assign command    = s_tdata[2:0];
  assign address    = s_tdata[6:3];
  assign write_data = s_tdata[14:7];

  // Architectural state
  logic        two_bank_mode, two_bank_mode_next;
  logic        selected_bank, selected_bank_next;
  logic        dac_on, dac_on_next;
  logic [7:0]  length_count, length_count_next;
  logic [2:0]  volume_code, volume_code_next;
  logic [10:0] freq_value, freq_value_next;
  logic        length_enable, length_enable_next;
  logic        channel_on, channel_on_next;
  logic [4:0]  play_index, play_index_next;
  logic        play_bank, play_bank_next;
  logic [11:0] period_count, period_count_next;
  logic [3:0]  current_sample, current_sample_next;
  logic [3:0]  last_output, last_output_next;

  // Pipeline control
  logic                  a_valid;
  logic                  a_adv;
  logic                  accept;
  bwsc_pkg::a_stage_t    a_stage, a_stage_next;

  // Pattern store
  logic [7:0]  wave_mem [32];
  logic [31:0] row_valid;
  logic [4:0]  raddr;
  logic [4:0]  waddr;
  logic        wen;
  logic [7:0]  rdata;
  logic        rd_valid;

  // Per-command decode
  logic [11:0] period_dec;
  logic [11:0] reload;
  logic [11:0] reload_trig;
  logic [7:0]  length_inc;
  logic [7:0]  reg_rd;
  logic        fetch;
  logic        tick_stopped;

  // Result stage
  logic [3:0]  nibble;
  logic [3:0]  cs_use;
  logic [6:0]  product;
  logic [3:0]  scaled;
  logic [7:0]  rd_out_next;

  assign a_adv    = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || a_adv;
  assign accept   = s_tvalid && s_tready;

  assign period_dec  = period_count - 12'd1;
  // Ticks reload from the current frequency; a trigger uses the high bits it writes.
  assign reload      = bwsc_pkg::PERIOD_BASE - {1'b0, freq_value};
  assign reload_trig = bwsc_pkg::PERIOD_BASE - {1'b0, write_data[2:0], freq_value[7:0]};
  assign length_inc  = length_count + 8'd1;

  assign tick_stopped = accept && (command == bwsc_pkg::CMD_TICK) && (period_count == 12'd0);

  // Register read mux; unlisted addresses read zero.
  always_comb begin
    unique case (address)
      bwsc_pkg::REG_CTRL:    reg_rd = {dac_on, selected_bank, two_bank_mode, 5'd0};
      bwsc_pkg::REG_VOLUME:  reg_rd = {volume_code, 5'd0};
      bwsc_pkg::REG_FREQ_HI: reg_rd = {1'b0, length_enable, 6'd0};
      default:               reg_rd = 8'd0;
    endcase
  end

  // Next state for the accepted command.
  always_comb begin
    two_bank_mode_next = two_bank_mode;
    selected_bank_next = selected_bank;
    dac_on_next        = dac_on;
    length_count_next  = length_count;
    volume_code_next   = volume_code;
    freq_value_next    = freq_value;
    length_enable_next = length_enable;
    channel_on_next    = channel_on;
    play_index_next    = play_index;
    play_bank_next     = play_bank;
    period_count_next  = period_count;
    fetch              = 1'b0;
    unique case (command)
      bwsc_pkg::CMD_TICK: begin
        // Stopped period stays stopped.
        if (period_count != 12'd0) begin
          period_count_next = period_dec;
          if (period_dec == 12'd0) begin
            period_count_next = reload;
            fetch             = 1'b1;
            play_index_next   = play_index + 5'd1;
            if (play_index == 5'd31) begin
              play_bank_next = play_bank ^ two_bank_mode;
            end
          end
        end
      end
      bwsc_pkg::CMD_LENGTH: begin
        if (channel_on && length_enable) begin
          length_count_next = length_inc;
          if (length_inc == 8'd0) begin
            channel_on_next = 1'b0;
          end
        end
      end
      bwsc_pkg::CMD_REG_WR: begin
        unique case (address)
          bwsc_pkg::REG_CTRL: begin
            two_bank_mode_next = write_data[5];
            selected_bank_next = write_data[6];
            dac_on_next        = write_data[7];
            if (!write_data[7]) begin
              channel_on_next = 1'b0;
            end
          end
          bwsc_pkg::REG_LENGTH:  length_count_next = write_data;
          bwsc_pkg::REG_VOLUME:  volume_code_next = write_data[7:5];
          bwsc_pkg::REG_FREQ_LO: freq_value_next = {freq_value[10:8], write_data};
          bwsc_pkg::REG_FREQ_HI: begin
            freq_value_next    = {write_data[2:0], freq_value[7:0]};
            length_enable_next = write_data[6];
            // Trigger: restart playback from the start of the pattern.
            if (write_data[7]) begin
              channel_on_next   = dac_on;
              period_count_next = reload_trig;
              play_index_next   = 5'd0;
              play_bank_next    = two_bank_mode ? 1'b0 : selected_bank;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Stage A payload: what the result stage needs besides the memory data.
  always_comb begin
    a_stage_next.is_tick   = (command == bwsc_pkg::CMD_TICK);
    a_stage_next.fetch     = fetch;
    a_stage_next.nib_lo    = play_index[0];
    a_stage_next.is_ram_rd = (command == bwsc_pkg::CMD_RAM_RD);
    a_stage_next.rd_reg    = (command == bwsc_pkg::CMD_REG_RD) ? reg_rd : 8'd0;
    a_stage_next.chan_on   = channel_on;
    a_stage_next.vol       = volume_code;
  end

  // Ticks read the playing bank; host access goes to the bank not selected.
  assign raddr = (command == bwsc_pkg::CMD_TICK) ? {play_bank, play_index[4:1]}
                                                 : {~selected_bank, address};
  assign waddr = {~selected_bank, address};
  assign wen   = accept && (command == bwsc_pkg::CMD_RAM_WR);

  always_ff @(posedge clk) begin
    if (wen) begin
      wave_mem[waddr] <= write_data;
    end
    if (accept) begin
      rdata    <= wave_mem[raddr];
      rd_valid <= row_valid[raddr];
      a_stage  <= a_stage_next;
    end
  end

  // Result stage: pick the nibble, scale, and hold output between ticks.
  assign nibble      = a_stage.nib_lo ? rdata[3:0] : rdata[7:4];
  assign cs_use      = a_stage.fetch ? (rd_valid ? nibble : 4'd0) : current_sample;
  assign product     = {3'd0, cs_use} * {4'd0, bwsc_pkg::vol_mult(a_stage.vol)};
  assign scaled      = product[5:2];
  assign current_sample_next = cs_use;
  assign last_output_next    = a_stage.is_tick ? (a_stage.chan_on ? scaled : 4'd0)
                                               : last_output;
  assign rd_out_next = a_stage.is_ram_rd ? (rd_valid ? rdata : 8'd0) : a_stage.rd_reg;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      m_tdata <= {4'd0, last_output_next, rd_out_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      two_bank_mode  <= 1'b0;
      selected_bank  <= 1'b0;
      dac_on         <= 1'b0;
      length_count   <= 8'd0;
      volume_code    <= 3'd0;
      freq_value     <= 11'd0;
      length_enable  <= 1'b0;
      channel_on     <= 1'b0;
      play_index     <= 5'd0;
      play_bank      <= 1'b0;
      period_count   <= 12'd0;
      current_sample <= 4'd0;
      last_output    <= 4'd0;
      row_valid      <= 32'd0;
      a_valid        <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        two_bank_mode <= two_bank_mode_next;
        selected_bank <= selected_bank_next;
        dac_on        <= dac_on_next;
        length_count  <= length_count_next;
        volume_code   <= volume_code_next;
        freq_value    <= freq_value_next;
        length_enable <= length_enable_next;
        channel_on    <= channel_on_next;
        play_index    <= play_index_next;
        play_bank     <= play_bank_next;
        period_count  <= period_count_next;
      end
      if (wen) begin
        row_valid[waddr] <= 1'b1;
      end
      if (a_adv) begin
        current_sample <= current_sample_next;
        last_output    <= last_output_next;
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `BWSC_ASSERT_NOW(a_chan_needs_dac, clk, rst, channel_on, dac_on)
  `BWSC_ASSERT_NOW(a_no_overrun, clk, rst, accept, (!a_valid || a_adv))
  `BWSC_ASSERT_NEXT(a_stopped_period, clk, rst, tick_stopped, (period_count == 12'd0))
  `BWSC_ASSERT_NEXT(a_reload_nonzero, clk, rst, (accept && fetch), (period_count != 12'd0))

endmodule

// ----- verif/tb.sv -----
// Testbench for the banked wave sound channel: directed table, then random command traffic.
module tb;

  // Command and register codes that the package leaves unnamed.
  localparam logic [2:0] CMD_RSVD6     = 3'd6;
  localparam logic [2:0] CMD_RSVD7     = 3'd7;
  localparam logic [3:0] REG_UNUSED_LO = 4'd5;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int STEADY_ITEMS  = 300;     // tail of the run with no idling on either side
  localparam int HOLDOFF_START = 600;     // receiver cycle at which the long hold-off begins
  localparam int HOLDOFF_LEN   = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0] rd;
    logic [3:0] smp;
  } chan_result_t;

  typedef struct packed {
    logic [2:0]   cmd;
    logic [3:0]   addr;
    logic [7:0]   wd;
    logic         typed;   // expected result given in the row, not by the channel model
    chan_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [2:0] command, [6:3] address, [14:7] write_data, [15] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] read_data, [11:8] sample, [15:12] zero

  // Row-supplied expectation, held alongside the transaction on offer.
  logic         row_typed;
  chan_result_t row_res;

  logic         steady_tail;
  logic         sender_gaps_on;
  int           wrong_fields;
  chan_result_t pending_results [$];
  stim_row_t    dir_rows [$];

  // Channel model state.
  logic        two_bank, sel_bank, dac_en, chan_on, len_en, play_bank;
  logic [7:0]  len_cnt;
  logic [2:0]  vol_code;
  logic [10:0] freq;
  logic [4:0]  play_idx;
  logic [3:0]  cur_smp, out_smp;
  logic [11:0] period;
  logic [3:0]  wave_mem [64];
  int unsigned quarter_gain [8] = '{0, 4, 2, 1, 3, 3, 3, 3};

  banked_wave_sound_channel dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the channel model by one command and return the result it produces.
  task automatic step_channel(input logic [2:0] cmd, input logic [3:0] addr,
                              input logic [7:0] wd, output chan_result_t res);
    logic [5:0]  ram_idx;
    int unsigned scaled;
    res = '0;
    // RAM access always lands in the bank that is not selected for playback
    ram_idx = {~sel_bank, addr, 1'b0};
    case (cmd)
      bwsc_pkg::CMD_TICK: begin
        // a stopped period counter stays at zero and fetches nothing
        if (period != 12'd0) begin
          period = period - 12'd1;
          if (period == 12'd0) begin
            period   = bwsc_pkg::PERIOD_BASE - {1'b0, freq};
            cur_smp  = wave_mem[{play_bank, play_idx}];
            play_idx = play_idx + 5'd1;
            if (play_idx == 5'd0) play_bank = play_bank ^ two_bank;
          end
        end
        scaled  = (cur_smp * quarter_gain[vol_code]) / 4;
        out_smp = chan_on ? scaled[3:0] : 4'd0;
      end
      bwsc_pkg::CMD_LENGTH: begin
        if (chan_on && len_en) begin
          len_cnt = len_cnt + 8'd1;
          if (len_cnt == 8'd0) chan_on = 1'b0;
        end
      end
      bwsc_pkg::CMD_REG_WR: begin
        case (addr)
          bwsc_pkg::REG_CTRL: begin
            two_bank = wd[5];
            sel_bank = wd[6];
            dac_en   = wd[7];
            if (!dac_en) chan_on = 1'b0;
          end
          bwsc_pkg::REG_LENGTH:  len_cnt = wd;
          bwsc_pkg::REG_VOLUME:  vol_code = wd[7:5];
          bwsc_pkg::REG_FREQ_LO: freq[7:0] = wd;
          bwsc_pkg::REG_FREQ_HI: begin
            freq[10:8] = wd[2:0];
            len_en     = wd[6];
            if (wd[7]) begin
              // trigger: restart playback from the start of the bank
              chan_on   = dac_en;
              period    = bwsc_pkg::PERIOD_BASE - {1'b0, freq};
              play_idx  = 5'd0;
              play_bank = two_bank ? 1'b0 : sel_bank;
            end
          end
          default: ;
        endcase
      end
      bwsc_pkg::CMD_REG_RD: begin
        case (addr)
          bwsc_pkg::REG_CTRL:    res.rd = {dac_en, sel_bank, two_bank, 5'd0};
          bwsc_pkg::REG_VOLUME:  res.rd = {vol_code, 5'd0};
          bwsc_pkg::REG_FREQ_HI: res.rd = {1'b0, len_en, 6'd0};
          default:               res.rd = 8'h00;
        endcase
      end
      bwsc_pkg::CMD_RAM_WR: begin
        wave_mem[ram_idx]         = wd[7:4];
        wave_mem[ram_idx | 6'd1]  = wd[3:0];
      end
      bwsc_pkg::CMD_RAM_RD: res.rd = {wave_mem[ram_idx], wave_mem[ram_idx | 6'd1]};
      default: ;
    endcase
    res.smp = out_smp;
  endtask

  function automatic stim_row_t mk_row(input logic [2:0] cmd, input logic [3:0] addr,
                                       input logic [7:0] wd, input logic typed,
                                       input logic [7:0] rd, input logic [3:0] smp);
    stim_row_t row;
    row.cmd     = cmd;
    row.addr    = addr;
    row.wd      = wd;
    row.typed   = typed;
    row.res.rd  = rd;
    row.res.smp = smp;
    return row;
  endfunction

  // Mostly ticks and well-formed register traffic that keeps the channel playing,
  // with the rest spread over every command, address and data byte.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row      = '0;
    pick     = $urandom_range(0, 99);
    row.addr = 4'($urandom_range(0, 15));
    row.wd   = 8'($urandom_range(0, 255));
    if (pick < 50) begin
      row.cmd = bwsc_pkg::CMD_TICK;
    end else if (pick < 58) begin
      row.cmd = bwsc_pkg::CMD_LENGTH;
    end else if (pick < 70) begin
      row.cmd = bwsc_pkg::CMD_REG_WR;
      if ($urandom_range(0, 7) != 0) begin
        row.addr = 4'($urandom_range(bwsc_pkg::REG_CTRL, bwsc_pkg::REG_FREQ_HI));
      end
      case (row.addr)
        bwsc_pkg::REG_CTRL:    if ($urandom_range(0, 7) != 0) row.wd[7] = 1'b1;
        bwsc_pkg::REG_LENGTH:  if ($urandom_range(0, 1) != 0) row.wd[7:4] = 4'hf;
        bwsc_pkg::REG_FREQ_LO: if ($urandom_range(0, 3) != 0) row.wd[7:4] = 4'hf;
        bwsc_pkg::REG_FREQ_HI: begin
          // keep the period short most of the time so samples play often
          if ($urandom_range(0, 3) != 0) row.wd[2:0] = 3'b111;
          if ($urandom_range(0, 1) != 0) row.wd[7] = 1'b1;
        end
        default: ;
      endcase
    end else if (pick < 78) begin
      row.cmd = bwsc_pkg::CMD_REG_RD;
      if ($urandom_range(0, 3) != 0) begin
        row.addr = 4'($urandom_range(bwsc_pkg::REG_CTRL, bwsc_pkg::REG_FREQ_HI));
      end
    end else if (pick < 88) begin
      row.cmd = bwsc_pkg::CMD_RAM_WR;
    end else if (pick < 96) begin
      row.cmd = bwsc_pkg::CMD_RAM_RD;
    end else begin
      row.cmd = ($urandom_range(0, 1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
    end
    return row;
  endfunction

  // Drop valid for a random burst now and then while sender gaps are on, except in the steady tail.
  task automatic sender_pace();
    int gap;
    if (!steady_tail && sender_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= 16'($urandom_range(0, 65535));
      end
    end
  endtask

  // Offer one transaction and hold it until the block accepts it.
  task automatic send_row(input stim_row_t row);
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tdata   <= {1'b0, row.wd, row.addr, row.cmd};
    row_typed <= row.typed;
    row_res   <= row.res;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sender: reset, directed table, random traffic, then drain and report.
  initial begin
    stim_row_t row;
    two_bank  = 1'b0;
    sel_bank  = 1'b0;
    dac_en    = 1'b0;
    chan_on   = 1'b0;
    len_en    = 1'b0;
    play_bank = 1'b0;
    len_cnt   = 8'd0;
    vol_code  = 3'd0;
    freq      = 11'd0;
    play_idx  = 5'd0;
    cur_smp   = 4'd0;
    out_smp   = 4'd0;
    period    = 12'd0;
    foreach (wave_mem[i]) wave_mem[i] = 4'd0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = 16'd0;
    row_typed      = 1'b0;
    row_res        = '0;
    steady_tail    = 1'b0;
    sender_gaps_on = 1'b1;
    wrong_fields   = 0;

    dir_rows = '{
      // stopped period: a tick right after reset fetches nothing
      mk_row(bwsc_pkg::CMD_TICK,   4'd0,                  8'h00, 1'b1, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_RD, bwsc_pkg::REG_CTRL,    8'h00, 1'b1, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_RAM_RD, 4'd0,                  8'h00, 1'b1, 8'h00, 4'h0),
      // two-bank mode, bank one selected, DAC on: RAM traffic goes to bank zero
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_CTRL,    8'he0, 1'b1, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_RD, bwsc_pkg::REG_CTRL,    8'h00, 1'b1, 8'he0, 4'h0),
      mk_row(bwsc_pkg::CMD_RAM_WR, 4'd15,                 8'hff, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_RAM_WR, 4'd0,                  8'h5a, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_RAM_RD, 4'd15,                 8'h00, 1'b1, 8'hff, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_VOLUME,  8'h20, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_RD, bwsc_pkg::REG_VOLUME,  8'h00, 1'b1, 8'h20, 4'h0),
      // highest frequency, length counting on, trigger
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_FREQ_LO, 8'hff, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_FREQ_HI, 8'hc7, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_RD, bwsc_pkg::REG_FREQ_HI, 8'h00, 1'b1, 8'h40, 4'h0),
      mk_row(bwsc_pkg::CMD_TICK,   4'd0,                  8'h00, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_TICK,   4'd0,                  8'h00, 1'b0, 8'h00, 4'h0),
      // length at its top value: one length clock overflows it and stops the channel
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_LENGTH,  8'hff, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_LENGTH, 4'd0,                  8'h00, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_TICK,   4'd0,                  8'h00, 1'b0, 8'h00, 4'h0),
      // unlisted register addresses and unused commands
      mk_row(bwsc_pkg::CMD_REG_RD, REG_UNUSED_LO,         8'h00, 1'b1, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_WR, REG_UNUSED_HI,         8'hff, 1'b0, 8'h00, 4'h0),
      mk_row(CMD_RSVD6,            4'd15,                 8'hff, 1'b1, 8'h00, 4'h0),
      mk_row(CMD_RSVD7,            4'd0,                  8'h00, 1'b1, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_VOLUME,  8'he0, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_WR, bwsc_pkg::REG_CTRL,    8'h00, 1'b0, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_RD, bwsc_pkg::REG_LENGTH,  8'h00, 1'b1, 8'h00, 4'h0),
      mk_row(bwsc_pkg::CMD_REG_RD, bwsc_pkg::REG_FREQ_LO, 8'h00, 1'b1, 8'h00, 4'h0)
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      sender_pace();
      send_row(dir_rows[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 128 == 0) sender_gaps_on = ($urandom_range(0, 3) != 0);
      if (i >= RANDOM_ITEMS - STEADY_ITEMS) steady_tail = 1'b1;
      row = random_row();
      sender_pace();
      send_row(row);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wrong_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: random stall bursts, with one long hold-off that backs up the block.
  initial begin
    int  hold_left;
    int  rx_cycles;
    bit  stalls_on;
    hold_left = 0;
    rx_cycles = 0;
    stalls_on = 1'b1;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 64 == 0) stalls_on = ($urandom_range(0, 3) != 0);
      if (rx_cycles == HOLDOFF_START) begin
        hold_left = HOLDOFF_LEN;
      end else if (hold_left == 0 && stalls_on && !steady_tail &&
                   $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 8);
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Predict on every accepted command; check every result transaction in order.
  always @(posedge clk) begin : scoreboard
    chan_result_t want;
    chan_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        step_channel(s_tdata[2:0], s_tdata[6:3], s_tdata[14:7], want);
        if (row_typed) want = row_res;
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.rd  = m_tdata[7:0];
        got.smp = m_tdata[11:8];
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual %h", $time, got);
          wrong_fields++;
        end else begin
          want = pending_results.pop_front();
          if (got.rd !== want.rd) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rd, got.rd);
            wrong_fields++;
          end
          if (got.smp !== want.smp) begin
            $display("%0t: sample expected %h actual %h", $time, want.smp, got.smp);
            wrong_fields++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    int watch_cycles;
    watch_cycles = 0;
    while (watch_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      watch_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- banked_wave_sound_channel.f -----
+incdir+rtl
rtl/bwsc_pkg.sv
rtl/banked_wave_sound_channel.sv
verif/tb.sv
